// File: hdl/msp_fe_pkg.sv
// shared types, constants and checksum helper for the frame encoder
`timescale 1ns / 1ps

package msp_fe_pkg;

   // command codes
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   // version codes
   localparam logic VER_1 = 1'b0;
   localparam logic VER_2 = 1'b1;

   // header characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_X      = 8'h58;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] V2_FLAG     = 8'h00;

   localparam logic [15:0] V1_MAX_LENGTH = 16'd255;
   localparam logic [7:0]  CRC_POLY      = 8'hD5;

   // byte position within one item's burst
   localparam int unsigned POS_W = 4;
   typedef logic [POS_W-1:0] pos_type;

   localparam pos_type V1_HDR_LAST = 4'd4;
   localparam pos_type V1_CHK_POS  = 4'd5;
   localparam pos_type V2_HDR_LAST = 4'd7;
   localparam pos_type V2_CHK_POS  = 4'd8;
   localparam pos_type PL_DATA_POS = 4'd0;
   localparam pos_type PL_CHK_POS  = 4'd1;

   typedef enum logic [1:0] {
      KIND_ERROR    = 2'd0,
      KIND_START_V1 = 2'd1,
      KIND_START_V2 = 2'd2,
      KIND_PAYLOAD  = 2'd3
   } kind_type;

   // descriptor of the bytes one accepted item produces
   typedef struct packed {
      kind_type    kind;
      logic        crc_mode;
      logic [15:0] message_id;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
      logic        closes;
   } burst_type;

   // one byte of crc-8 dvb-s2, msb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: hdl/msp_fe_tracker.sv
// frame state tracking and item classification
`timescale 1ns / 1ps

module msp_fe_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  command,
   input  logic                  version,
   input  logic [15:0]           message_id,
   input  logic [15:0]           payload_length,
   input  logic [7:0]            data_byte,
   output msp_fe_pkg::burst_type burst
);
   import msp_fe_pkg::*;

   logic        open_ff, open_in;
   logic        second_ff, second_in;
   logic [15:0] remaining_ff, remaining_in;

   always_comb begin
      open_in              = open_ff;
      second_in            = second_ff;
      remaining_in         = remaining_ff;
      burst.kind           = KIND_ERROR;
      burst.crc_mode       = second_ff;
      burst.message_id     = message_id;
      burst.payload_length = payload_length;
      burst.data_byte      = data_byte;
      burst.closes         = 1'b0;
      if (command == CMD_START) begin
         open_in = 1'b0;
         if (version == VER_1 && payload_length > V1_MAX_LENGTH) begin
            burst.kind = KIND_ERROR;
         end else begin
            burst.kind     = (version == VER_2) ? KIND_START_V2 : KIND_START_V1;
            burst.crc_mode = version;
            second_in      = version;
            remaining_in   = payload_length;
            open_in        = (payload_length != 16'd0);
            burst.closes   = (payload_length == 16'd0);
         end
      end else if (open_ff) begin
         burst.kind   = KIND_PAYLOAD;
         remaining_in = remaining_ff - 16'd1;
         burst.closes = (remaining_ff == 16'd1);
         open_in      = (remaining_ff != 16'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         second_ff    <= 1'b0;
         remaining_ff <= 16'd0;
      end else if (accept) begin
         open_ff      <= open_in;
         second_ff    <= second_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

// File: hdl/msp_fe_serializer.sv
// burst register, byte sequencing, running checksum and result register
`timescale 1ns / 1ps

module msp_fe_serializer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  msp_fe_pkg::burst_type in_burst,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [7:0]            out_byte,
   output logic                  out_frame_end,
   output logic                  out_run_last,
   output logic                  out_error
);
   import msp_fe_pkg::*;

   burst_type  burst_ff;
   logic       burst_valid_ff, burst_valid_in;
   pos_type    pos_ff, pos_in;
   logic [7:0] check_ff, check_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff, rsp_last_ff, rsp_err_ff;

   logic       out_load, burst_done, in_accept;
   pos_type    last_pos;
   logic [7:0] cur_byte;
   logic       cur_fold, cur_crc, cur_err, is_check;

   always_comb begin
      cur_byte = 8'h00;
      cur_fold = 1'b0;
      cur_crc  = 1'b0;
      cur_err  = 1'b0;
      last_pos = 4'd0;
      case (burst_ff.kind)
         KIND_START_V1: begin
            last_pos = burst_ff.closes ? V1_CHK_POS : V1_HDR_LAST;
            case (pos_ff)
               4'd0:    cur_byte = CHAR_DOLLAR;
               4'd1:    cur_byte = CHAR_M;
               4'd2:    cur_byte = CHAR_LT;
               4'd3: begin
                  cur_byte = burst_ff.payload_length[7:0];
                  cur_fold = 1'b1;
               end
               4'd4: begin
                  cur_byte = burst_ff.message_id[7:0];
                  cur_fold = 1'b1;
               end
               default: cur_byte = check_ff;
            endcase
         end
         KIND_START_V2: begin
            last_pos = burst_ff.closes ? V2_CHK_POS : V2_HDR_LAST;
            cur_crc  = 1'b1;
            cur_fold = (pos_ff >= 4'd3) && (pos_ff <= V2_HDR_LAST);
            case (pos_ff)
               4'd0:    cur_byte = CHAR_DOLLAR;
               4'd1:    cur_byte = CHAR_X;
               4'd2:    cur_byte = CHAR_LT;
               4'd3:    cur_byte = V2_FLAG;
               4'd4:    cur_byte = burst_ff.message_id[7:0];
               4'd5:    cur_byte = burst_ff.message_id[15:8];
               4'd6:    cur_byte = burst_ff.payload_length[7:0];
               4'd7:    cur_byte = burst_ff.payload_length[15:8];
               default: cur_byte = check_ff;
            endcase
         end
         KIND_PAYLOAD: begin
            last_pos = burst_ff.closes ? PL_CHK_POS : PL_DATA_POS;
            cur_crc  = burst_ff.crc_mode;
            if (pos_ff == PL_DATA_POS) begin
               cur_byte = burst_ff.data_byte;
               cur_fold = 1'b1;
            end else begin
               cur_byte = check_ff;
            end
         end
         default: begin
            cur_err = 1'b1;
         end
      endcase
   end

   assign is_check   = burst_ff.closes && (pos_ff == last_pos) && !cur_err;
   assign out_load   = burst_valid_ff && (!rsp_valid_ff || out_ready);
   assign burst_done = out_load && (pos_ff == last_pos);
   assign in_ready   = !burst_valid_ff || burst_done;
   assign in_accept  = in_valid && in_ready;

   always_comb begin
      burst_valid_in = burst_valid_ff;
      pos_in         = pos_ff;
      if (in_accept) begin
         burst_valid_in = 1'b1;
         pos_in         = 4'd0;
      end else if (burst_done) begin
         burst_valid_in = 1'b0;
      end else if (out_load) begin
         pos_in = pos_ff + 4'd1;
      end
   end

   always_comb begin
      check_in = check_ff;
      if (out_load) begin
         if ((burst_ff.kind == KIND_START_V1 || burst_ff.kind == KIND_START_V2)
             && pos_ff == 4'd0) begin
            check_in = 8'h00;
         end else if (cur_fold) begin
            check_in = cur_crc ? crc8_byte(check_ff, cur_byte) : (check_ff ^ cur_byte);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pos_ff         <= 4'd0;
         check_ff       <= 8'h00;
      end else begin
         burst_valid_ff <= burst_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         pos_ff         <= pos_in;
         check_ff       <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         burst_ff <= in_burst;
      end
      if (out_load) begin
         rsp_byte_ff <= cur_byte;
         rsp_end_ff  <= is_check;
         rsp_last_ff <= (pos_ff == last_pos);
         rsp_err_ff  <= cur_err;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_byte      = rsp_byte_ff;
   assign out_frame_end = rsp_end_ff;
   assign out_run_last  = rsp_last_ff;
   assign out_error     = rsp_err_ff;

endmodule

// File: hdl/msp_frame_encoder.sv
// top level of the serial command frame encoder, versions 1 and 2
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | command, version, message_id,
//          |           |                      | payload_length, data_byte
//  rsp_    | out       | rsp_valid/rsp_ready  | out_byte, frame_end, run_last, error
//
//  one result byte leaves per cycle unless rsp_ready stalls; an item occupies the
//  burst register until its last byte moves to rsp_: 1 byte for an error, 1 or 2 for
//  a payload byte, 5 or 6 for a version 1 header, 8 or 9 for a version 2 header
//  the next item is taken in the cycle its predecessor's last byte moves to rsp_
//  synchronous active-high reset closes any open frame and empties both registers
//  a stall on rsp_ready holds the result register and, behind it, the burst

module msp_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic        req_version,
   input  logic [15:0] req_message_id,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_last,
   output logic        rsp_error
);
   import msp_fe_pkg::*;

   // descriptor for the item on req_, built from the frame state
   burst_type req_burst;
   logic      req_accept;

   assign req_accept = req_valid && req_ready;

   // frame state: open flag, version of the open frame, bytes still owed
   msp_fe_tracker u_tracker (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .command        (req_command),
      .version        (req_version),
      .message_id     (req_message_id),
      .payload_length (req_payload_length),
      .data_byte      (req_data_byte),
      .burst          (req_burst)
   );

   // holds the accepted item, steps through its bytes, folds the checksum
   msp_fe_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_burst      (req_burst),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_byte      (rsp_out_byte),
      .out_frame_end (rsp_frame_end),
      .out_run_last  (rsp_run_last),
      .out_error     (rsp_error)
   );

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the serial command frame encoder
`timescale 1ns / 1ps

module tb;
   import msp_fe_pkg::*;

   // generous cycle ceiling, several times the slowest correct run
   localparam int CYCLE_LIMIT = 300000;
   // cycles allowed for stray bytes after the last expected one
   localparam int TAIL_CYCLES = 30;

   // one byte as it should appear on the result channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
      logic       error;
   } wire_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_START;
   logic        req_version = VER_1;
   logic [15:0] req_message_id = '0;
   logic [15:0] req_payload_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_frame_end;
   logic        rsp_run_last;
   logic        rsp_error;

   // bytes still owed by the block, oldest first
   wire_byte_type wire_bytes_due[$];

   // predictor state, mirrors the encoder after every accepted item
   logic        open_frame = 1'b0;
   logic        v2_mode = 1'b0;
   logic [15:0] bytes_left = '0;
   logic [7:0]  frame_check = '0;

   // idling knobs, percent of cycles
   int sender_idle_pct = 0;
   int rx_stall_pct = 0;
   // receiver hold-off, counted down by the receiver process
   int rx_hold = 0;

   int mismatches = 0;
   int items_sent = 0;
   int bytes_seen = 0;
   int frames_closed = 0;
   int rejects_seen = 0;
   int input_stalls = 0;
   int cycle_count = 0;

   msp_frame_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_version        (req_version),
      .req_message_id     (req_message_id),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_run_last       (rsp_run_last),
      .rsp_error          (rsp_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // crc-8 dvb-s2, one data bit at a time through the feedback tap
   function automatic logic [7:0] dvb_s2_fold(input logic [7:0] crc, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[7] ^ b[i];
         crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

   // works out the bytes one accepted item should produce and queues them
   function automatic void encode_item(input logic cmd, input logic ver,
                                       input logic [15:0] id, input logic [15:0] len,
                                       input logic [7:0] data);
      logic [7:0] burst_bytes[$];
      logic       closes = 1'b0;
      logic       rejected = 1'b0;
      logic [7:0] crc;
      wire_byte_type e;
      if (cmd == CMD_START) begin
         // any unfinished frame is dropped without its checksum
         open_frame = 1'b0;
         if (ver == VER_1 && len > V1_MAX_LENGTH) begin
            rejected = 1'b1;
            burst_bytes.push_back(8'h00);
         end else begin
            v2_mode = (ver == VER_2);
            burst_bytes.push_back(CHAR_DOLLAR);
            if (ver == VER_1) begin
               burst_bytes.push_back(CHAR_M);
               burst_bytes.push_back(CHAR_LT);
               burst_bytes.push_back(len[7:0]);
               burst_bytes.push_back(id[7:0]);
               frame_check = len[7:0] ^ id[7:0];
            end else begin
               burst_bytes.push_back(CHAR_X);
               burst_bytes.push_back(CHAR_LT);
               burst_bytes.push_back(V2_FLAG);
               burst_bytes.push_back(id[7:0]);
               burst_bytes.push_back(id[15:8]);
               burst_bytes.push_back(len[7:0]);
               burst_bytes.push_back(len[15:8]);
               // crc covers the flag onwards
               crc = 8'h00;
               for (int i = 3; i < 8; i++) begin
                  crc = dvb_s2_fold(crc, burst_bytes[i]);
               end
               frame_check = crc;
            end
            bytes_left = len;
            if (len == 16'd0) begin
               burst_bytes.push_back(frame_check);
               closes = 1'b1;
            end else begin
               open_frame = 1'b1;
            end
         end
      end else if (!open_frame) begin
         rejected = 1'b1;
         burst_bytes.push_back(8'h00);
      end else begin
         burst_bytes.push_back(data);
         frame_check = v2_mode ? dvb_s2_fold(frame_check, data) : frame_check ^ data;
         bytes_left  = bytes_left - 16'd1;
         if (bytes_left == 16'd0) begin
            burst_bytes.push_back(frame_check);
            closes     = 1'b1;
            open_frame = 1'b0;
         end
      end
      for (int i = 0; i < burst_bytes.size(); i++) begin
         e.out_byte  = burst_bytes[i];
         e.run_last  = (i == burst_bytes.size() - 1);
         e.frame_end = closes && e.run_last;
         e.error     = rejected;
         wire_bytes_due.push_back(e);
      end
   endfunction

   // receiver: random stalls, or a counted hold-off when one is armed
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_ready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // result checker, compares each accepted byte with the oldest one owed
   always @(posedge clock) begin
      wire_byte_type exp_b;
      if (!reset) begin
         if (req_valid && !req_ready) begin
            input_stalls++;
         end
         if (rsp_valid && rsp_ready) begin
            bytes_seen++;
            if (wire_bytes_due.size() == 0) begin
               $error("unexpected result byte %h (frame_end %b run_last %b error %b)",
                      rsp_out_byte, rsp_frame_end, rsp_run_last, rsp_error);
               mismatches++;
            end else begin
               exp_b = wire_bytes_due.pop_front();
               if (rsp_out_byte !== exp_b.out_byte) begin
                  $error("out_byte: expected %h, got %h", exp_b.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_frame_end !== exp_b.frame_end) begin
                  $error("frame_end: expected %b, got %b", exp_b.frame_end, rsp_frame_end);
                  mismatches++;
               end
               if (rsp_run_last !== exp_b.run_last) begin
                  $error("run_last: expected %b, got %b", exp_b.run_last, rsp_run_last);
                  mismatches++;
               end
               if (rsp_error !== exp_b.error) begin
                  $error("error: expected %b, got %b", exp_b.error, rsp_error);
                  mismatches++;
               end
               if (exp_b.frame_end) begin
                  frames_closed++;
               end
               if (exp_b.error) begin
                  rejects_seen++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still owed",
                  cycle_count, wire_bytes_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // offers one item, entered and left at a falling edge; valid stays up
   // between back-to-back items so the caller must lower it before pausing
   task automatic send_item(input logic cmd, input logic ver, input logic [15:0] id,
                            input logic [15:0] len, input logic [7:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_version        <= ver;
      req_message_id     <= id;
      req_payload_length <= len;
      req_data_byte      <= data;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      encode_item(cmd, ver, id, len, data);
      items_sent++;
      @(negedge clock);
   endtask

   // start item, the data byte is junk the block must ignore
   task automatic send_start(input logic ver, input logic [15:0] id, input logic [15:0] len);
      send_item(CMD_START, ver, id, len, 8'($urandom_range(255)));
   endtask

   // payload item, version, id and length are junk the block must ignore
   task automatic send_payload(input logic [7:0] data);
      send_item(CMD_PAYLOAD, 1'($urandom_range(1)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)), data);
   endtask

   // sender goes quiet until every owed byte has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (wire_bytes_due.size() != 0);
   endtask

   // field extremes, both versions and every rejection and abandon case
   task automatic test_directed();
      sender_idle_pct = 0;
      rx_stall_pct    = 0;
      // payload before any frame has been opened
      send_item(CMD_PAYLOAD, VER_2, 16'hFFFF, 16'hFFFF, 8'hFF);
      // version 1, empty frame closes straight after the header
      send_item(CMD_START, VER_1, 16'hABCD, 16'h0000, 8'hFF);
      send_start(VER_1, 16'h00FF, 16'd3);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_payload(8'hA5);
      // frame just closed, so this one has nowhere to go
      send_payload(8'h3C);
      // version 1 lengths beyond a byte
      send_start(VER_1, 16'h5555, 16'd256);
      send_start(VER_1, 16'hFFFF, 16'hFFFF);
      // version 2, empty frame and a short one
      send_start(VER_2, 16'hFFFF, 16'h0000);
      send_start(VER_2, 16'h0000, 16'd2);
      send_payload(8'h80);
      send_payload(8'h01);
      // long version 2 frame dropped by a version 1 start
      send_start(VER_2, 16'h1234, 16'hFFFF);
      send_payload(8'h5A);
      send_start(VER_1, 16'h0000, 16'd255);
      send_payload(8'h7E);
      // oversize start also drops the open frame
      send_start(VER_1, 16'hAAAA, 16'd300);
      send_payload(8'hC3);
      send_start(VER_2, 16'h8001, 16'd1);
      send_payload(8'hFF);
      wait_drained();
   endtask

   // mostly whole frames with random content, some noise and cut-off frames
   task automatic run_random_frame();
      int          roll;
      int          cut;
      logic        ver;
      logic [15:0] len;
      roll = $urandom_range(99);
      ver  = 1'($urandom_range(1));
      if (roll < 8) begin
         // stray payload, rejected unless a cut-off frame is still open
         send_payload(8'($urandom_range(255)));
      end else if (roll < 16) begin
         send_start(VER_1, 16'($urandom_range(65535)), 16'($urandom_range(65535, 256)));
      end else if (roll < 28) begin
         // random-length frame, usually cut short, which a later start then drops
         len = (ver == VER_1) ? 16'($urandom_range(255, 1)) : 16'($urandom_range(65535, 1));
         send_start(ver, 16'($urandom_range(65535)), len);
         cut = $urandom_range(4);
         repeat (cut) send_payload(8'($urandom_range(255)));
      end else begin
         len = ($urandom_range(9) == 0) ? 16'($urandom_range(40, 7)) : 16'($urandom_range(6));
         send_start(ver, 16'($urandom_range(65535)), len);
         repeat (len) send_payload(8'($urandom_range(255)));
      end
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
      int target;
      target          = items_sent + n;
      sender_idle_pct = idle_pct;
      rx_stall_pct    = stall_pct;
      while (items_sent < target) begin
         run_random_frame();
      end
      // pause the sender until the block has caught up
      wait_drained();
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      sender_idle_pct = 0;
      rx_stall_pct    = 0;
      @(posedge clock);
      rx_hold = 300;
      @(negedge clock);
      send_start(VER_2, 16'($urandom_range(65535)), 16'd28);
      repeat (28) send_payload(8'($urandom_range(255)));
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_traffic(0, 0, 90);
      test_random_traffic(82, 0, 90);
      test_random_traffic(0, 82, 90);
      test_random_traffic(35, 35, 90);
      test_backpressure();

      // let any stray byte show up before judging
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d items across both versions; checked %0d bytes,",
               items_sent, bytes_seen);
      $display("%0d closed frames, %0d rejects, input held off for %0d cycles",
               frames_closed, rejects_seen, input_stalls);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/msp_fe_pkg.sv
hdl/msp_fe_tracker.sv
hdl/msp_fe_serializer.sv
hdl/msp_frame_encoder.sv
tb/sv/tb.sv
